### hw/rtl/assert_macros.svh
// Assertion macros for the descriptor queue chunker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/dqc_pkg.sv
// Types and constants shared by the descriptor queue chunker modules.
package dqc_pkg;

   // default descriptor queue depth
   localparam int DEF_QUEUE_DEPTH = 64;

   // depth of the command queue between front and back
   localparam int CMDQ_DEPTH = 2;

   // request command codes
   localparam logic [1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [1:0] CMD_DRAIN   = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;

   // chunk limit in bytes, and width of the bytes-left counter
   localparam int          LEFT_W      = 19;
   localparam logic [18:0] CHUNK_BYTES = 19'd2048;
   localparam int          SIZE_W      = 12;

   // control word fields
   localparam int WIDE_UNIT_BIT = 26;
   localparam int SRC_MODE_LO   = 23;
   localparam int DST_MODE_LO   = 21;

   // address modes
   localparam logic [1:0] MODE_INC = 2'b00;
   localparam logic [1:0] MODE_DEC = 2'b01;

   // descriptor store word: {control, destination, source}
   localparam int DESC_W = 96;

   typedef enum logic [1:0] {
      OP_ENQ   = 2'd0,
      OP_DRAIN = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] src;
      logic [31:0] dst;
      logic [31:0] ctrl;
   } cmd_item_type;

   // handshake between the command queue and the back end
   typedef struct packed {
      logic         pop;
   } cmdq_pop_type;

   typedef struct packed {
      logic         empty;
      cmd_item_type item;
   } cmdq_head_type;

endpackage

### hw/rtl/dqc_ram.sv
// Generic simple dual-port RAM with registered read.
module dqc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/dqc_front.sv
// Front end: accepts requests, decodes the command and feeds the command queue.
module dqc_front import dqc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_command,
   input  logic [31:0]  req_src_addr,
   input  logic [31:0]  req_dst_addr,
   input  logic [31:0]  req_control_word,
   input  logic         q_full,
   output logic         q_push,
   output cmd_item_type q_item
);

   logic         hold_valid_ff, hold_valid_in;
   cmd_item_type hold_item_ff, hold_item_in;
   logic         take;
   op_type       op_dec;

   // decode the command code
   always_comb begin
      unique case (req_command)
         CMD_ENQUEUE: op_dec = OP_ENQ;
         CMD_DRAIN:   op_dec = OP_DRAIN;
         CMD_CLEAR:   op_dec = OP_CLEAR;
         default:     op_dec = OP_NOP;
      endcase
   end

   assign busy   = hold_valid_ff && q_full;
   assign take   = start && !busy;
   assign q_push = hold_valid_ff && !q_full;
   assign q_item = hold_item_ff;

   // load a new request, or drop the held one once it moves on
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_item_in  = hold_item_ff;
      if (take) begin
         hold_valid_in     = 1'b1;
         hold_item_in.op   = op_dec;
         hold_item_in.src  = req_src_addr;
         hold_item_in.dst  = req_dst_addr;
         hold_item_in.ctrl = req_control_word;
      end else if (q_push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_item_ff <= hold_item_in;
   end

endmodule

### hw/rtl/dqc_cmd_fifo.sv
// Short command queue between the front and back ends.
module dqc_cmd_fifo import dqc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_item_type  push_item,
   output logic          full,
   input  cmdq_pop_type  pop_ctl,
   output cmdq_head_type head
);

   localparam int PW = $clog2(CMDQ_DEPTH);
   localparam int NW = $clog2(CMDQ_DEPTH + 1);

   cmd_item_type  slot_ff [CMDQ_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == NW'(CMDQ_DEPTH));
   assign head.empty = (count_ff == '0);
   assign head.item  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop_ctl.pop && !head.empty;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store pushed commands
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/dqc_back.sv
// Back end: runs queued commands on the descriptor store and chunk state.
`include "assert_macros.svh"
module dqc_back import dqc_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  cmdq_head_type head,
   output cmdq_pop_type  pop_ctl,
   output logic          rsp_valid,
   output logic          rsp_accepted,
   output logic          rsp_chunk_valid,
   output logic [31:0]   rsp_chunk_src,
   output logic [31:0]   rsp_chunk_dst,
   output logic [31:0]   rsp_chunk_control,
   output logic          rsp_last_of_entry,
   output logic          rsp_queue_empty
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_CHUNK = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [IW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              active_ff, active_in;
   logic [31:0]       cur_src_ff, cur_src_in;
   logic [31:0]       cur_dst_ff, cur_dst_in;
   logic [LEFT_W-1:0] left_ff, left_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_accepted_ff, rsp_accepted_in;
   logic              rsp_chunk_valid_ff, rsp_chunk_valid_in;
   logic [31:0]       rsp_src_ff, rsp_src_in;
   logic [31:0]       rsp_dst_ff, rsp_dst_in;
   logic [31:0]       rsp_ctrl_ff, rsp_ctrl_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_empty_ff, rsp_empty_in;

   logic              wr_en, rd_en;
   logic [IW-1:0]     tail;
   logic [IW:0]       tail_sum;
   logic [DESC_W-1:0] rd_data;

   logic [31:0]       d_src, d_dst, d_ctrl;
   logic              wide;
   logic [LEFT_W-1:0] left_eff, left_after;
   logic [SIZE_W-1:0] size;
   logic [SIZE_W-1:0] units;
   logic [31:0]       base_src, base_dst;
   logic [IW-1:0]     head_next;

   // tail slot: head plus count, wrapped at the queue depth
   assign tail_sum = {1'b0, head_ff} + (IW + 1)'(count_ff);
   assign tail     = (tail_sum >= (IW + 1)'(QUEUE_DEPTH))
                   ? IW'(tail_sum - (IW + 1)'(QUEUE_DEPTH)) : tail_sum[IW-1:0];
   assign head_next = (head_ff == IW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   dqc_ram #(
      .WIDTH (DESC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail),
      .wr_data ({head.item.ctrl, head.item.dst, head.item.src}),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // split the head descriptor into its next chunk
   always_comb begin
      d_src    = rd_data[31:0];
      d_dst    = rd_data[63:32];
      d_ctrl   = rd_data[95:64];
      wide     = d_ctrl[WIDE_UNIT_BIT];
      base_src = active_ff ? cur_src_ff : d_src;
      base_dst = active_ff ? cur_dst_ff : d_dst;
      if (active_ff) begin
         left_eff = left_ff;
      end else if (wide) begin
         left_eff = {1'b0, d_ctrl[15:0], 2'b00};
      end else begin
         left_eff = {2'b00, d_ctrl[15:0], 1'b0};
      end
      size       = (left_eff > CHUNK_BYTES) ? CHUNK_BYTES[SIZE_W-1:0] : left_eff[SIZE_W-1:0];
      units      = wide ? (size >> 2) : (size >> 1);
      left_after = left_eff - LEFT_W'(size);
   end

   // sequence the commands
   always_comb begin
      state_in           = state_ff;
      head_in            = head_ff;
      count_in           = count_ff;
      active_in          = active_ff;
      cur_src_in         = cur_src_ff;
      cur_dst_in         = cur_dst_ff;
      left_in            = left_ff;
      pop_ctl.pop        = 1'b0;
      wr_en              = 1'b0;
      rd_en              = 1'b0;
      rsp_valid_in       = 1'b0;
      rsp_accepted_in    = 1'b0;
      rsp_chunk_valid_in = 1'b0;
      rsp_src_in         = '0;
      rsp_dst_in         = '0;
      rsp_ctrl_in        = '0;
      rsp_last_in        = 1'b0;
      rsp_empty_in       = (count_ff == '0);
      unique case (state_ff)
         ST_IDLE: begin
            if (!head.empty) begin
               pop_ctl.pop = 1'b1;
               unique case (head.item.op)
                  OP_ENQ: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff < CW'(QUEUE_DEPTH)) begin
                        wr_en           = 1'b1;
                        count_in        = count_ff + 1'b1;
                        rsp_accepted_in = 1'b1;
                        rsp_empty_in    = 1'b0;
                     end
                  end
                  OP_DRAIN: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        state_in = ST_CHUNK;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     rsp_empty_in = 1'b1;
                     head_in      = '0;
                     count_in     = '0;
                     active_in    = 1'b0;
                     cur_src_in   = '0;
                     cur_dst_in   = '0;
                     left_in      = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_CHUNK: begin
            state_in           = ST_IDLE;
            rsp_valid_in       = 1'b1;
            rsp_chunk_valid_in = 1'b1;
            rsp_src_in         = base_src;
            rsp_dst_in         = base_dst;
            rsp_ctrl_in        = {d_ctrl[31:16], 16'(units)};
            unique case (d_ctrl[SRC_MODE_LO+1:SRC_MODE_LO])
               MODE_INC: cur_src_in = base_src + 32'(size);
               MODE_DEC: cur_src_in = base_src - 32'(size);
               default:  cur_src_in = base_src;
            endcase
            unique case (d_ctrl[DST_MODE_LO+1:DST_MODE_LO])
               MODE_INC: cur_dst_in = base_dst + 32'(size);
               MODE_DEC: cur_dst_in = base_dst - 32'(size);
               default:  cur_dst_in = base_dst;
            endcase
            left_in   = left_after;
            active_in = 1'b1;
            if (left_after == '0) begin
               rsp_last_in = 1'b1;
               active_in   = 1'b0;
               head_in     = head_next;
               count_in    = count_ff - 1'b1;
            end
            rsp_empty_in = (count_in == '0);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         head_ff            <= '0;
         count_ff           <= '0;
         active_ff          <= 1'b0;
         cur_src_ff         <= '0;
         cur_dst_ff         <= '0;
         left_ff            <= '0;
         rsp_valid_ff       <= 1'b0;
         rsp_accepted_ff    <= 1'b0;
         rsp_chunk_valid_ff <= 1'b0;
         rsp_last_ff        <= 1'b0;
      end else begin
         state_ff           <= state_in;
         head_ff            <= head_in;
         count_ff           <= count_in;
         active_ff          <= active_in;
         cur_src_ff         <= cur_src_in;
         cur_dst_ff         <= cur_dst_in;
         left_ff            <= left_in;
         rsp_valid_ff       <= rsp_valid_in;
         rsp_accepted_ff    <= rsp_accepted_in;
         rsp_chunk_valid_ff <= rsp_chunk_valid_in;
         rsp_last_ff        <= rsp_last_in;
      end
   end

   // hold result payload
   always_ff @(posedge clock) begin
      rsp_src_ff   <= rsp_src_in;
      rsp_dst_ff   <= rsp_dst_in;
      rsp_ctrl_ff  <= rsp_ctrl_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_chunk_valid   = rsp_chunk_valid_ff;
   assign rsp_chunk_src     = rsp_src_ff;
   assign rsp_chunk_dst     = rsp_dst_ff;
   assign rsp_chunk_control = rsp_ctrl_ff;
   assign rsp_last_of_entry = rsp_last_ff;
   assign rsp_queue_empty   = rsp_empty_ff;

   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CW'(QUEUE_DEPTH))
   `ASSERT_IMPLIES(a_active_has_entry, clock, reset, active_ff, count_ff != '0)
   `ASSERT_NEXT(a_chunk_responds, clock, reset, state_ff == ST_CHUNK, rsp_chunk_valid_ff)
   `ASSERT_IMPLIES(a_flags_exclusive, clock, reset, rsp_accepted_ff,
      rsp_valid_ff && !rsp_chunk_valid_ff)
   `ASSERT_IMPLIES(a_last_is_chunk, clock, reset, rsp_last_ff, rsp_chunk_valid_ff)

endmodule

### hw/rtl/dma_descriptor_queue_chunker.sv
// Top level of the DMA descriptor queue with chunk splitting.
//
// Requests: a request is taken on a rising edge with start high and busy low.
// req_command selects enqueue (store src/dst/control), drain (emit one chunk
// of the head descriptor, at most 2048 bytes) or clear (empty the queue).
// Every request yields exactly one response, in request order, shown for one
// cycle with rsp_valid high; the receiver cannot stall it.
//
// Path: a request passes the front register and the command queue; its
// response is registered. A drain that finds a descriptor also passes
// ST_CHUNK, since the descriptor store is a RAM with a registered read port.
// Flow: the back end handles enqueue, clear and unused codes in ST_IDLE and
// a chunk in ST_IDLE then ST_CHUNK; a 2-entry command queue plus one front
// register absorb bursts, and busy rises when both are full.
//
// Reset: synchronous, active high; the queue comes up empty, no response is
// pending, and the descriptor store itself is not cleared.
module dma_descriptor_queue_chunker import dqc_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_dst_addr,
   input  logic [31:0] req_control_word,
   output logic        rsp_valid,
   output logic        rsp_accepted,
   output logic        rsp_chunk_valid,
   output logic [31:0] rsp_chunk_src,
   output logic [31:0] rsp_chunk_dst,
   output logic [31:0] rsp_chunk_control,
   output logic        rsp_last_of_entry,
   output logic        rsp_queue_empty
);

   logic          q_full, q_push;
   cmd_item_type  q_item;
   cmdq_pop_type  pop_ctl;
   cmdq_head_type q_head;

   dqc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_src_addr     (req_src_addr),
      .req_dst_addr     (req_dst_addr),
      .req_control_word (req_control_word),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (q_item)
   );

   dqc_cmd_fifo u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop_ctl   (pop_ctl),
      .head      (q_head)
   );

   dqc_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (q_head),
      .pop_ctl           (pop_ctl),
      .rsp_valid         (rsp_valid),
      .rsp_accepted      (rsp_accepted),
      .rsp_chunk_valid   (rsp_chunk_valid),
      .rsp_chunk_src     (rsp_chunk_src),
      .rsp_chunk_dst     (rsp_chunk_dst),
      .rsp_chunk_control (rsp_chunk_control),
      .rsp_last_of_entry (rsp_last_of_entry),
      .rsp_queue_empty   (rsp_queue_empty)
   );

endmodule
